// File: design/tone_lut_white_balance_gain_assert.svh
// assertion macros for the tone table and white-balance gain block
// expects clk and arst_n in the scope of each use
`ifndef TONE_LUT_WHITE_BALANCE_GAIN_ASSERT_SVH
`define TONE_LUT_WHITE_BALANCE_GAIN_ASSERT_SVH
`ifndef SYNTH
`define TLWB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tlwb assertion failed");
`define TLWB_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("tlwb assertion failed");
`else
`define TLWB_ASSERT(lbl, prop)
`define TLWB_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// File: design/tlwb_pkg.sv
// shared types and constants of the tone table and white-balance gain block
// no dependencies
package tlwb_pkg;

	localparam int PIX_W   = 8;
	localparam int GAIN_W  = 16;
	localparam int PROD_W  = PIX_W + GAIN_W;
	localparam int CFG_IDX_W = 2;
	localparam int IN_DATA_W  = 5 * PIX_W;
	localparam int OUT_DATA_W = 3 * PIX_W;
	localparam int TONE_DEPTH = 256;
	localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd4096;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_BLUE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_GREEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_RED   = 2'd2;

	typedef struct packed {
		logic             wr_en;
		logic [PIX_W-1:0] wr_addr;
		logic [PIX_W-1:0] wr_data;
		logic             ld_s1;
		logic             ld_s2;
		logic             ld_s3;
	} ctrl_t;

endpackage

// File: design/tlwb_channel.sv
// one color channel: tone table copy, gain multiply, shift and saturate
// depends on tlwb_pkg
module tlwb_channel #(
	parameter int GAIN_FRAC_BITS = 12
) (
	input  logic                        clk,
	input  tlwb_pkg::ctrl_t             ctrl,
	input  logic [tlwb_pkg::PIX_W-1:0]  pix,
	input  logic [tlwb_pkg::GAIN_W-1:0] gain,
	output logic [tlwb_pkg::PIX_W-1:0]  res
);

	logic [tlwb_pkg::PIX_W-1:0]  tone_mem_q [tlwb_pkg::TONE_DEPTH];
	logic [tlwb_pkg::PIX_W-1:0]  toned_s1;
	logic [tlwb_pkg::PROD_W-1:0] prod_s2;
	logic [tlwb_pkg::PROD_W-1:0] shifted;
	logic [tlwb_pkg::PIX_W-1:0]  res_s3;

	// table write and registered read
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			tone_mem_q[ctrl.wr_addr] <= ctrl.wr_data;
		end
		if (ctrl.ld_s1) begin
			toned_s1 <= tone_mem_q[pix];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_s2) begin
			prod_s2 <= tlwb_pkg::PROD_W'(toned_s1) * tlwb_pkg::PROD_W'(gain);
		end
	end

	assign shifted = prod_s2 >> GAIN_FRAC_BITS;

	// saturate to one byte
	always_ff @(posedge clk) begin
		if (ctrl.ld_s3) begin
			if (|shifted[tlwb_pkg::PROD_W-1:tlwb_pkg::PIX_W]) begin
				res_s3 <= '1;
			end else begin
				res_s3 <= shifted[tlwb_pkg::PIX_W-1:0];
			end
		end
	end

	assign res = res_s3;

endmodule

// File: design/tone_lut_white_balance_gain.sv
// top level: tone table lookup with per-channel white-balance gain
// depends on tlwb_pkg, tlwb_channel and tone_lut_white_balance_gain_assert.svh
//
// channel  dir  tdata (low bit up)                          tuser  tlast
// s_       in   pixel_b pixel_g pixel_r entry_index entry_value  op  frame_end_in
// m_       out  out_b out_g out_r                           -      frame_end_out
// cfg_     in   cfg_index selects gain_blue, gain_green, gain_red; cfg_data 16 bits
//
// one word per cycle unless the output stalls; a pixel is registered after each stage below
// stages: table read, gain multiply, shift and saturate
// table writes give no word and leave the pipeline at once
// stalls hold each stage; bubbles ahead are filled while the output waits
// reset clears valid bits and sets all gains to unity; the table is not cleared
`include "tone_lut_white_balance_gain_assert.svh"
module tone_lut_white_balance_gain #(
	parameter int GAIN_FRAC_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [tlwb_pkg::IN_DATA_W-1:0]  s_tdata,  // pixel_b pixel_g pixel_r entry_index entry_value
	input  logic                            s_tuser,  // op
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [tlwb_pkg::OUT_DATA_W-1:0] m_tdata,  // out_b, out_g, out_r
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tlwb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tlwb_pkg::GAIN_W-1:0]     cfg_data
);

	logic [tlwb_pkg::GAIN_W-1:0] gain_b_q;
	logic [tlwb_pkg::GAIN_W-1:0] gain_g_q;
	logic [tlwb_pkg::GAIN_W-1:0] gain_r_q;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic last_s1;
	logic last_s2;
	logic last_s3;
	logic ready_s1;
	logic ready_s2;
	logic ready_s3;
	logic in_acc;
	logic pix_acc;

	tlwb_pkg::ctrl_t ctrl;

	logic [tlwb_pkg::PIX_W-1:0] res_b;
	logic [tlwb_pkg::PIX_W-1:0] res_g;
	logic [tlwb_pkg::PIX_W-1:0] res_r;

	// gain registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_b_q <= tlwb_pkg::GAIN_UNITY;
			gain_g_q <= tlwb_pkg::GAIN_UNITY;
			gain_r_q <= tlwb_pkg::GAIN_UNITY;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tlwb_pkg::REG_GAIN_BLUE:  gain_b_q <= cfg_data;
				tlwb_pkg::REG_GAIN_GREEN: gain_g_q <= cfg_data;
				tlwb_pkg::REG_GAIN_RED:   gain_r_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow
	assign ready_s3 = !valid_s3 || m_tready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;

	assign in_acc  = s_tvalid && s_tready;
	assign pix_acc = in_acc && (s_tuser == tlwb_pkg::OP_PIXEL);

	assign ctrl.wr_en   = in_acc && (s_tuser == tlwb_pkg::OP_WRITE);
	assign ctrl.wr_addr = s_tdata[4*tlwb_pkg::PIX_W-1:3*tlwb_pkg::PIX_W];
	assign ctrl.wr_data = s_tdata[5*tlwb_pkg::PIX_W-1:4*tlwb_pkg::PIX_W];
	assign ctrl.ld_s1   = pix_acc;
	assign ctrl.ld_s2   = ready_s2 && valid_s1;
	assign ctrl.ld_s3   = ready_s3 && valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= pix_acc;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_s1) begin
			last_s1 <= s_tlast;
		end
		if (ctrl.ld_s2) begin
			last_s2 <= last_s1;
		end
		if (ctrl.ld_s3) begin
			last_s3 <= last_s2;
		end
	end

	tlwb_channel #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_chan_b (
		.clk  (clk),
		.ctrl (ctrl),
		.pix  (s_tdata[tlwb_pkg::PIX_W-1:0]),
		.gain (gain_b_q),
		.res  (res_b)
	);

	tlwb_channel #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_chan_g (
		.clk  (clk),
		.ctrl (ctrl),
		.pix  (s_tdata[2*tlwb_pkg::PIX_W-1:tlwb_pkg::PIX_W]),
		.gain (gain_g_q),
		.res  (res_g)
	);

	tlwb_channel #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_chan_r (
		.clk  (clk),
		.ctrl (ctrl),
		.pix  (s_tdata[3*tlwb_pkg::PIX_W-1:2*tlwb_pkg::PIX_W]),
		.gain (gain_r_q),
		.res  (res_r)
	);

	assign m_tvalid = valid_s3;
	assign m_tdata  = {res_r, res_g, res_b};
	assign m_tlast  = last_s3;

	// table writes never enter the pipeline, pixels always do
	`TLWB_ASSERT_NEXT(a_write_no_word, in_acc && s_tuser == tlwb_pkg::OP_WRITE, !valid_s1)
	`TLWB_ASSERT_NEXT(a_pixel_enters, pix_acc, valid_s1)
	// an empty output stage leaves room at the input
	`TLWB_ASSERT(a_empty_out_ready, !m_tvalid |-> s_tready)
	// a stalled middle stage keeps its word
	`TLWB_ASSERT_NEXT(a_s2_hold, valid_s2 && !ready_s2, valid_s2 && $stable(last_s2))

endmodule

// File: bench/tb.sv
// testbench for tone_lut_white_balance_gain: table loads, pixels and gain writes
// with random stalls on both streams, checked against a scoreboard predictor
// depends on tlwb_pkg and the tone_lut_white_balance_gain design
`timescale 1ns / 100ps

module tb;

	localparam int PIX_W = tlwb_pkg::PIX_W;
	localparam int GAIN_W = tlwb_pkg::GAIN_W;
	localparam int PROD_W = tlwb_pkg::PROD_W;
	localparam int CFG_IDX_W = tlwb_pkg::CFG_IDX_W;
	localparam int IN_DATA_W = tlwb_pkg::IN_DATA_W;
	localparam int OUT_DATA_W = tlwb_pkg::OUT_DATA_W;
	localparam int TONE_DEPTH = tlwb_pkg::TONE_DEPTH;
	localparam int GAIN_FRAC_BITS = 12;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 72;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		logic [PIX_W-1:0] b;
		logic [PIX_W-1:0] g;
		logic [PIX_W-1:0] r;
		logic             frame_end;
	} pixel_word_t;

	class pixel_scoreboard;
		logic [PIX_W-1:0]  tone[TONE_DEPTH];
		logic [GAIN_W-1:0] gain_b;
		logic [GAIN_W-1:0] gain_g;
		logic [GAIN_W-1:0] gain_r;
		pixel_word_t       expected_pixels[$];
		int                errors;
		int                results_seen;

		function new();
			foreach (tone[i])
				tone[i] = '0;
			gain_b = tlwb_pkg::GAIN_UNITY;
			gain_g = tlwb_pkg::GAIN_UNITY;
			gain_r = tlwb_pkg::GAIN_UNITY;
			errors = 0;
			results_seen = 0;
		endfunction

		function void set_gain(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
			case (idx)
				tlwb_pkg::REG_GAIN_BLUE:  gain_b = val;
				tlwb_pkg::REG_GAIN_GREEN: gain_g = val;
				tlwb_pkg::REG_GAIN_RED:   gain_r = val;
				default: ;
			endcase
		endfunction

		function logic [PIX_W-1:0] toned_gain(logic [PIX_W-1:0] level,
				logic [GAIN_W-1:0] gain);
			logic [PROD_W-1:0] prod;
			logic [PROD_W-1:0] scaled;
			prod = tone[level] * gain;
			scaled = prod >> GAIN_FRAC_BITS;
			return (scaled > 255) ? {PIX_W{1'b1}} : scaled[PIX_W-1:0];
		endfunction

		function void note_word(logic op, logic [IN_DATA_W-1:0] data, logic last);
			pixel_word_t w;
			if (op == tlwb_pkg::OP_WRITE) begin
				tone[data[3*PIX_W +: PIX_W]] = data[4*PIX_W +: PIX_W];
			end else begin
				w.b = toned_gain(data[0 +: PIX_W], gain_b);
				w.g = toned_gain(data[PIX_W +: PIX_W], gain_g);
				w.r = toned_gain(data[2*PIX_W +: PIX_W], gain_r);
				w.frame_end = last;
				expected_pixels.push_back(w);
			end
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		task check_word(logic [OUT_DATA_W-1:0] data, logic last);
			pixel_word_t w;
			results_seen++;
			if (expected_pixels.size() == 0) begin
				report("output word with nothing expected");
				return;
			end
			w = expected_pixels.pop_front();
			if (data[0 +: PIX_W] !== w.b)
				report($sformatf("out_b %0d, expected %0d", data[0 +: PIX_W], w.b));
			if (data[PIX_W +: PIX_W] !== w.g)
				report($sformatf("out_g %0d, expected %0d", data[PIX_W +: PIX_W], w.g));
			if (data[2*PIX_W +: PIX_W] !== w.r)
				report($sformatf("out_r %0d, expected %0d", data[2*PIX_W +: PIX_W], w.r));
			if (last !== w.frame_end)
				report($sformatf("frame_end_out %0b, expected %0b", last, w.frame_end));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [GAIN_W-1:0]     cfg_data = '0;

	pixel_scoreboard sb = new();
	int              pixels_sent = 0;
	bit              steady = 1'b0;
	bit              entry_loaded[TONE_DEPTH];
	logic [PIX_W-1:0] loaded_list[$];

	tone_lut_white_balance_gain #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (cfg_valid && cfg_ready)
			sb.set_gain(cfg_index, cfg_data);
		if (s_tvalid && s_tready)
			sb.note_word(s_tuser, s_tdata, s_tlast);
		if (m_tvalid && m_tready)
			sb.check_word(m_tdata, m_tlast);
	end

	task automatic send_word(logic op, logic [IN_DATA_W-1:0] data, logic last);
		int r;
		int gap;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			gap = 0;
		else if (r < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= data;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op == tlwb_pkg::OP_PIXEL)
			pixels_sent++;
	endtask

	task automatic send_pixel(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g, logic [PIX_W-1:0] r,
			logic last);
		send_word(tlwb_pkg::OP_PIXEL, {8'($urandom), 8'($urandom), r, g, b}, last);
	endtask

	task automatic send_entry(logic [PIX_W-1:0] idx, logic [PIX_W-1:0] val);
		if (!entry_loaded[idx]) begin
			entry_loaded[idx] = 1'b1;
			loaded_list.push_back(idx);
		end
		send_word(tlwb_pkg::OP_WRITE, {val, idx, 24'($urandom)}, 1'($urandom));
	endtask

	function automatic logic [PIX_W-1:0] loaded_level();
		return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
	endfunction

	// hold the stream until every pixel word is back and the pipeline is empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.results_seen < pixels_sent) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_gain(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// the spare index must be ignored
	task automatic apply_gains(logic [GAIN_W-1:0] b, logic [GAIN_W-1:0] g,
			logic [GAIN_W-1:0] r);
		write_gain(tlwb_pkg::REG_GAIN_BLUE, b);
		write_gain(tlwb_pkg::REG_GAIN_GREEN, g);
		write_gain(tlwb_pkg::REG_GAIN_RED, r);
		write_gain(REG_SPARE, 16'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : sink
		int run;
		int stall;
		int r;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (steady) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				run = $urandom_range(1, 16);
				r = $urandom_range(0, 99);
				if (r < 30)
					stall = 0;
				else if (r < 93)
					stall = $urandom_range(1, 4);
				else
					stall = $urandom_range(15, 60);
				m_tready <= 1'b1;
				repeat (run) @(posedge clk);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	initial begin
		#5000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gains are unity
		send_entry(8'd0, 8'hFF);
		send_entry(8'd255, 8'h00);
		send_entry(8'd128, 8'h80);
		send_entry(8'd127, 8'h7F);
		send_entry(8'd85, 8'hAA);
		send_entry(8'd170, 8'h55);
		send_pixel(8'd0, 8'd255, 8'd128, 1'b0);
		send_pixel(8'd255, 8'd0, 8'd127, 1'b1);
		send_pixel(8'd85, 8'd170, 8'd0, 1'b0);
		// overwrite then read back at once
		send_entry(8'd0, 8'h01);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);

		// zero gain, full gain with saturation, just under unity
		settle();
		apply_gains(16'd0, 16'hFFFF, 16'd4095);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd128, 8'd128, 8'd128, 1'b1);
		send_pixel(8'd255, 8'd85, 8'd170, 1'b0);
		send_pixel(8'd127, 8'd127, 8'd127, 1'b0);

		settle();
		apply_gains(16'hFFFF, 16'd0, 16'd1);
		send_pixel(8'd128, 8'd0, 8'd128, 1'b1);
		send_pixel(8'd85, 8'd170, 8'd255, 1'b0);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			case (p)
				0: apply_gains(tlwb_pkg::GAIN_UNITY, tlwb_pkg::GAIN_UNITY,
					tlwb_pkg::GAIN_UNITY);
				1: apply_gains(16'hFFFF, 16'd0, 16'($urandom));
				3: apply_gains(16'd0, 16'hFFFF, tlwb_pkg::GAIN_UNITY);
				4: apply_gains(16'($urandom_range(0, 8191)), 16'($urandom_range(0, 8191)),
					16'($urandom_range(0, 8191)));
				default: apply_gains(16'($urandom), 16'($urandom), 16'($urandom));
			endcase
			steady = (p == 3);
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 30)
					send_entry(8'($urandom), 8'($urandom));
				else
					send_pixel(loaded_level(), loaded_level(), loaded_level(),
						$urandom_range(0, 7) == 0);
			end
			steady = 1'b0;
		end

		settle();
		if (sb.expected_pixels.size() != 0)
			sb.report($sformatf("%0d expected words never came", sb.expected_pixels.size()));
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
